// ===== src/lmts_pkg.sv =====
// Package for the LED matrix transition sequencer: item types, codes, modes.
// No dependencies.
package lmts_pkg;

  typedef enum logic [2:0] {
    FUNC_TICK  = 3'd0,
    FUNC_LOAD  = 3'd1,
    FUNC_START = 3'd2,
    FUNC_DRAW  = 3'd3,
    FUNC_ERROR = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_ROW   = 2'd2,
    CMD_SHOW  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_RUN     = 3'd0,
    MODE_HORIZ   = 3'd1,
    MODE_INSTANT = 3'd2,
    MODE_SNAKE   = 3'd3,
    MODE_WRITER  = 3'd4,
    MODE_SHUFFLE = 3'd5,
    MODE_IDLE    = 3'd7
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RUN_SCAN,
    ST_HORIZ,
    ST_ROWS,
    ST_BUILD,
    ST_SHUF_DIV,
    ST_SHUF_RDJ,
    ST_SHUF_RDC,
    ST_SHUF_SWAP,
    ST_EMIT_PIX,
    ST_ERR,
    ST_CLEAR,
    ST_SHOW
  } state_e;

  localparam logic [23:0] ColorRed   = 24'hFF0000;
  localparam logic [23:0] ColorGreen = 24'h00FF00;
  localparam logic [23:0] ColorBlue  = 24'h0000FF;
  localparam logic [23:0] ColorWhite = 24'hFFFFFF;
  localparam logic [31:0] RunMs      = 32'd150;
  localparam logic [31:0] HorizMs    = 32'd60;
  localparam logic [31:0] FlashMs    = 32'd30;
  localparam logic [31:0] ShuffleMs  = 32'd100;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] now_ms;
    logic [15:0] random_value;
    logic [3:0]  target_row;
    logic [10:0] target_bits;
    logic [2:0]  transition_kind;
    logic        error_visible;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  led_index;
    logic [3:0]  row_index;
    logic [10:0] row_bits;
    logic [23:0] pixel_color;
    logic        last;
  } out_word_t;

  // Control from the sequencer to the shared divider.
  typedef struct packed {
    logic       start;
    logic [15:0] dividend;
    logic [6:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic       busy;
    logic [6:0] remainder;
  } div_rsp_t;

endpackage

// ===== src/led_matrix_transition_sequencer_unit.sv =====
// LED matrix transition sequencer, top level.
// The first command is registered at the output after the dispatch state; a shuffle
// tick first waits for the bit-serial remainder unit. A shuffle start walks all
// leds, one per cycle. One item at a time; the next is taken once the last
// command has entered the output register. Reset is asynchronous active low
// and returns to idle with an empty target.
module led_matrix_transition_sequencer_unit #(
  parameter int LED_ROWS    = 10,
  parameter int LED_COLUMNS = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lmts_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lmts_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_data_i
);
  import lmts_pkg::*;

  localparam int Total = LED_ROWS * LED_COLUMNS;
  localparam int RW = $clog2(LED_ROWS);
  localparam int CW = $clog2(LED_COLUMNS);
  localparam int LW = $clog2(Total + 1);
  localparam logic [LW-1:0] TotalL = LW'(Total);
  localparam logic [LW-1:0] ColsL  = LW'(LED_COLUMNS);

  logic [1:0] color_q;
  logic [LED_COLUMNS-1:0] map_q [LED_ROWS];
  logic has_q;
  mode_e mode_q;
  logic [LW-1:0] pos_q;
  logic phase_q;
  logic [31:0] nft_q;
  logic [LW-1:0] ctot_q, ccur_q;

  state_e st_q, st_d;
  in_word_t it_q;
  // walk counters: row / column, led counter for scans
  logic [RW-1:0] r_q;
  logic [CW-1:0] c_q;
  logic [LW-1:0] led_q;
  logic [6:0] pix_q;
  logic [23:0] pcol_q;
  logic [6:0] j_q, vj_q;
  logic [2:0] ecnt_q;

  logic out_v_q;
  out_word_t out_q;

  logic [23:0] act_col;
  always_comb begin
    unique case (color_q)
      2'd1: act_col = ColorRed;
      2'd2: act_col = ColorGreen;
      2'd3: act_col = ColorBlue;
      default: act_col = ColorWhite;
    endcase
  end

  // Serpentine led at walk row/column
  logic [LW-1:0] serp_led;
  always_comb begin
    if (!r_q[0]) serp_led = LW'(r_q * LED_COLUMNS + (LED_COLUMNS - 1 - c_q));
    else serp_led = LW'(r_q * LED_COLUMNS + c_q);
  end
  logic [LW-1:0] plain_led;
  assign plain_led = LW'(r_q * LED_COLUMNS + c_q);
  logic serp_lit, plain_lit;
  logic [CW-1:0] sc;
  assign sc = r_q[0] ? c_q : CW'(LED_COLUMNS - 1 - c_q);
  assign serp_lit = map_q[r_q][sc];
  assign plain_lit = map_q[r_q][c_q];

  // Registered copies of the walk row and column (unused)
  logic [RW-1:0] lr_q;
  logic [CW-1:0] lc_q;

  logic due;
  assign due = ~it_q.now_ms[31] ^ 1'b0;
  logic [31:0] diff;
  assign diff = it_q.now_ms - nft_q;

  // Shared remainder unit and candidate memory
  div_req_t dreq;
  div_rsp_t drsp;
  lmts_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic ram_we;
  logic [6:0] ram_wa, ram_wd, ram_ra, ram_rd;
  lmts_ram #(.Width(7), .Depth(128)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  logic out_free;
  assign out_free = !out_v_q || !out_stall_i;
  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (in_acc) st_d = ST_DISPATCH;
      default: st_d = st_q;
    endcase
  end

  // Sequencer: one register block carrying the working state but for the row/column copies
  logic emit_v;
  out_word_t emit_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= 2'd0;
      for (int i = 0; i < LED_ROWS; i++) map_q[i] <= '0;
      has_q <= 1'b0;
      mode_q <= MODE_IDLE;
      pos_q <= '0;
      phase_q <= 1'b0;
      nft_q <= '0;
      ctot_q <= '0;
      ccur_q <= '0;
      st_q <= ST_IDLE;
      out_v_q <= 1'b0;
      r_q <= '0;
      c_q <= '0;
      led_q <= '0;
      ecnt_q <= '0;
    end else begin
      if (cfg_valid_i) color_q <= cfg_data_i;
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      if (emit_v) begin
        out_v_q <= 1'b1;
        out_q <= emit_w;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            it_q <= in_word_i;
            st_q <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          st_q <= ST_IDLE;
          r_q <= '0;
          c_q <= '0;
          ecnt_q <= '0;
          unique case (it_q.func)
            FUNC_TICK: begin
              if (mode_q != MODE_IDLE && !diff[31]) begin
                unique case (mode_q)
                  MODE_RUN: begin
                    r_q <= RW'(pos_q / ColsL);
                    c_q <= CW'(pos_q % ColsL);
                    st_q <= ST_RUN_SCAN;
                  end
                  MODE_HORIZ: begin
                    c_q <= CW'(pos_q % ColsL);
                    st_q <= ST_HORIZ;
                  end
                  MODE_SNAKE, MODE_WRITER: begin
                    r_q <= RW'((pos_q % TotalL) / ColsL);
                    c_q <= CW'((pos_q % TotalL) % ColsL);
                    st_q <= ST_EMIT_PIX;
                  end
                  MODE_SHUFFLE: begin
                    if (ccur_q >= ctot_q || ctot_q > TotalL) mode_q <= MODE_IDLE;
                    else st_q <= ST_SHUF_DIV;
                  end
                  default: mode_q <= MODE_IDLE;
                endcase
              end
            end
            FUNC_LOAD: begin
              if (it_q.target_row < 4'(LED_ROWS))
                map_q[RW'(it_q.target_row)] <= it_q.target_bits[LED_COLUMNS-1:0];
            end
            FUNC_START: begin
              has_q <= 1'b1;
              if (it_q.transition_kind == 3'd2) begin
                st_q <= ST_ROWS;
              end else if (it_q.transition_kind == 3'd0 || it_q.transition_kind == 3'd1 ||
                           it_q.transition_kind == 3'd3 || it_q.transition_kind == 3'd4) begin
                mode_q <= mode_e'(it_q.transition_kind);
                pos_q <= '0;
                phase_q <= 1'b0;
                nft_q <= it_q.now_ms;
                st_q <= ST_CLEAR;
              end else begin
                mode_q <= MODE_SHUFFLE;
                ctot_q <= '0;
                ccur_q <= '0;
                nft_q <= it_q.now_ms;
                led_q <= '0;
                st_q <= ST_BUILD;
              end
            end
            FUNC_DRAW: if (has_q) st_q <= ST_ROWS;
            FUNC_ERROR: begin
              mode_q <= MODE_IDLE;
              st_q <= ST_CLEAR;
            end
            default: st_q <= ST_IDLE;
          endcase
        end
        ST_RUN_SCAN: begin
          if (pos_q >= TotalL) begin
            mode_q <= MODE_IDLE;
            st_q <= ST_IDLE;
          end else begin
            pos_q <= pos_q + 1'b1;
            if (c_q == CW'(LED_COLUMNS - 1)) begin
              c_q <= '0;
              r_q <= r_q + 1'b1;
            end else c_q <= c_q + 1'b1;
            if (serp_lit) begin
              pix_q <= 7'(serp_led);
              pcol_q <= act_col;
              nft_q <= it_q.now_ms + RunMs;
              st_q <= ST_EMIT_PIX;
              ecnt_q <= 3'd1;
            end
          end
        end
        ST_HORIZ: begin
          if (out_free) begin
            if (r_q == RW'(LED_ROWS - 1)) begin
              st_q <= ST_SHOW;
              if (!phase_q) begin
                phase_q <= 1'b1;
                nft_q <= it_q.now_ms + HorizMs;
              end else begin
                pos_q <= pos_q + 1'b1;
                phase_q <= 1'b0;
                nft_q <= it_q.now_ms;
                if (pos_q + 1'b1 >= ColsL) mode_q <= MODE_IDLE;
              end
            end else r_q <= r_q + 1'b1;
          end
        end
        ST_ROWS: begin
          if (out_free) begin
            if (r_q == RW'(LED_ROWS - 1)) begin
              mode_q <= MODE_IDLE;
              st_q <= ST_SHOW;
            end else r_q <= r_q + 1'b1;
          end
        end
        ST_BUILD: begin
          if (plain_lit) ctot_q <= ctot_q + 1'b1;
          if (led_q == TotalL - 1'b1) begin
            st_q <= ST_CLEAR;
            if (ctot_q == '0 && !plain_lit) mode_q <= MODE_IDLE;
          end
          led_q <= led_q + 1'b1;
          if (c_q == CW'(LED_COLUMNS - 1)) begin
            c_q <= '0;
            r_q <= r_q + 1'b1;
          end else c_q <= c_q + 1'b1;
        end
        ST_SHUF_DIV: begin
          ecnt_q <= 3'd1;
          if (ecnt_q != '0 && !drsp.busy) begin
            j_q <= 7'(ccur_q) + drsp.remainder;
            st_q <= ST_SHUF_RDJ;
            ecnt_q <= '0;
          end
        end
        ST_SHUF_RDJ: begin
          ecnt_q <= ecnt_q + 1'b1;
          if (ecnt_q == 3'd1) begin
            vj_q <= ram_rd;
            ecnt_q <= '0;
            st_q <= ST_SHUF_RDC;
          end
        end
        ST_SHUF_RDC: begin
          ecnt_q <= ecnt_q + 1'b1;
          if (ecnt_q == 3'd1) begin
            ecnt_q <= '0;
            st_q <= ST_SHUF_SWAP;
          end
        end
        ST_SHUF_SWAP: begin
          // write old cursor value to j; led at cursor is vj
          pix_q <= vj_q;
          r_q <= RW'(LW'(vj_q) / ColsL);
          c_q <= CW'(LW'(vj_q) % ColsL);
          ccur_q <= ccur_q + 1'b1;
          nft_q <= it_q.now_ms + ShuffleMs;
          if (ccur_q + 1'b1 >= ctot_q) mode_q <= MODE_IDLE;
          ecnt_q <= 3'd2;
          st_q <= ST_EMIT_PIX;
        end
        ST_EMIT_PIX: begin
          if (out_free) begin
            st_q <= ST_SHOW;
            if (ecnt_q == '0) begin
              if (!phase_q) begin
                phase_q <= 1'b1;
                nft_q <= it_q.now_ms + FlashMs;
              end else begin
                pos_q <= pos_q + 1'b1;
                phase_q <= 1'b0;
                nft_q <= it_q.now_ms;
                if (pos_q + 1'b1 >= TotalL) mode_q <= MODE_IDLE;
              end
            end
          end
        end
        ST_CLEAR: begin
          if (out_free) begin
            if (it_q.func == FUNC_ERROR && it_q.error_visible) st_q <= ST_ERR;
            else st_q <= ST_SHOW;
            ecnt_q <= '0;
          end
        end
        ST_ERR: begin
          if (out_free) begin
            if (ecnt_q == 3'd3) st_q <= ST_SHOW;
            ecnt_q <= ecnt_q + 1'b1;
          end
        end
        ST_SHOW: if (out_free) st_q <= ST_IDLE;
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // Build list entries in the memory and the swap writes
  always_comb begin
    ram_we = 1'b0;
    ram_wa = 7'(ctot_q);
    ram_wd = 7'(plain_led);
    ram_ra = j_q;
    dreq.start = (st_q == ST_SHUF_DIV) && (ecnt_q == '0);
    dreq.dividend = it_q.random_value;
    dreq.divisor = 7'(ctot_q - ccur_q);
    if (st_q == ST_BUILD && plain_lit) ram_we = 1'b1;
    if (st_q == ST_SHUF_RDC) ram_ra = 7'(ccur_q);
    if (st_q == ST_SHUF_SWAP) begin
      ram_we = 1'b1;
      ram_wa = j_q;
      ram_wd = ram_rd;
    end
  end

  // Commands
  logic [LW-1:0] cur_led;
  always_comb begin
    emit_v = 1'b0;
    emit_w = '0;
    cur_led = (mode_q == MODE_WRITER) ? plain_led : serp_led;
    if (out_free) begin
      unique case (st_q)
        ST_HORIZ: begin
          emit_v = 1'b1;
          emit_w.command = CMD_PIXEL;
          emit_w.led_index = 7'(serp_led);
          emit_w.pixel_color = (!phase_q || serp_lit) ? act_col : 24'd0;
        end
        ST_ROWS: begin
          emit_v = 1'b1;
          emit_w.command = CMD_ROW;
          emit_w.row_index = 4'(r_q);
          emit_w.row_bits = 11'(map_q[r_q]);
          emit_w.pixel_color = act_col;
        end
        ST_EMIT_PIX: begin
          emit_v = 1'b1;
          emit_w.command = CMD_PIXEL;
          if (ecnt_q == 3'd1) begin
            emit_w.led_index = pix_q;
            emit_w.pixel_color = pcol_q;
          end else if (ecnt_q == 3'd2) begin
            emit_w.led_index = pix_q;
            emit_w.pixel_color = plain_lit ? act_col : 24'd0;
          end else begin
            emit_w.led_index = 7'(cur_led);
            emit_w.pixel_color = (!phase_q ||
              ((mode_q == MODE_WRITER) ? plain_lit : serp_lit)) ? act_col : 24'd0;
          end
        end
        ST_CLEAR: begin
          emit_v = 1'b1;
          emit_w.command = CMD_CLEAR;
        end
        ST_ERR: begin
          emit_v = 1'b1;
          emit_w.command = CMD_PIXEL;
          emit_w.pixel_color = ColorRed;
          unique case (ecnt_q[1:0])
            2'd0: emit_w.led_index = 7'd0;
            2'd1: emit_w.led_index = 7'(LED_COLUMNS - 1);
            2'd2: emit_w.led_index = 7'((LED_ROWS - 1) * LED_COLUMNS);
            default: emit_w.led_index = 7'(Total - 1);
          endcase
        end
        ST_SHOW: begin
          emit_v = 1'b1;
          emit_w.command = CMD_SHOW;
          emit_w.last = 1'b1;
        end
        default: emit_v = 1'b0;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o = out_q;

  logic unused;
  assign unused = ^{st_d, due, lr_q, lc_q, led_q[0]};
  always_ff @(posedge clk_i) begin
    lr_q <= r_q;
    lc_q <= c_q;
  end
endmodule

// ===== src/lmts_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module lmts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/lmts_div.sv =====
// Bit-serial restoring remainder unit: 16-bit dividend by 7-bit divisor.
// Depends on lmts_pkg.
module lmts_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lmts_pkg::div_req_t req_i,
  output lmts_pkg::div_rsp_t rsp_o
);
  import lmts_pkg::*;

  logic [15:0] dvd_q, dvd_d;
  logic [6:0]  div_q, div_d;
  logic [7:0]  rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [7:0]  shifted;

  // One quotient bit per cycle
  always_comb begin
    dvd_d = dvd_q;
    div_d = div_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    shifted = {rem_q[6:0], dvd_q[15]};
    if (req_i.start) begin
      dvd_d = req_i.dividend;
      div_d = req_i.divisor;
      rem_d = 8'd0;
      cnt_d = 5'd16;
    end else if (cnt_q != 5'd0) begin
      dvd_d = {dvd_q[14:0], 1'b0};
      rem_d = (shifted >= {1'b0, div_q}) ? shifted - {1'b0, div_q} : shifted;
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = (cnt_q != 5'd0);
  assign rsp_o.remainder = rem_q[6:0];
endmodule
